// File: src/blsc_pkg.sv
// Shared types and constants for the bit-plane LED scanner.
// Used by the top level bitplane_led_scanner_core; no dependencies.
package blsc_pkg;

	localparam int OP_W        = 2;
	localparam int ADDR_W      = 7;
	localparam int DATA_W      = 8;
	localparam int BRIGHT_W    = 8;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

	localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd255;
	localparam logic [7:0]          ROUND_BIAS   = 8'd127;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_SWAP  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

endpackage

// File: src/bitplane_led_scanner_core.sv
// Double-buffered bit-plane LED scanner: frame memory, scan sequencer, output queue.
// Depends on blsc_pkg and blsc_ram.
// Write and swap transactions leave the input ready. A scan tick holds s_axis_tready low
// until its BYTES_PER_PLANE bytes are read through the single frame memory read port (one
// byte a cycle while the output queue has room); output stalls stretch this.
// The first byte of a tick passes the scan state, the registered read port and the output
// queue before it is valid; the rest follow one per cycle while the receiver takes them.
// A clear transaction runs a clearing pass over the back half of the frame memory, which
// holds the input off until the pass ends. Reset (arst_n low) clears all control state and
// sets brightness to full; a clearing pass over both halves follows before the input is ready.
module bitplane_led_scanner_core #(
	parameter int NUM_PLANES      = 4,
	parameter int BYTES_PER_PLANE = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [blsc_pkg::BRIGHT_W-1:0]      cfg_data,     // brightness
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [blsc_pkg::IN_TDATA_W-1:0]    s_axis_tdata, // address[6:0], data[14:7], zero
	input  logic [blsc_pkg::OP_W-1:0]          s_axis_tuser, // opcode[1:0]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [blsc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata, // shift_byte[7:0]
	output logic                               m_axis_tlast  // last_byte
);

	import blsc_pkg::*;

	localparam int FRAME_SIZE = NUM_PLANES * BYTES_PER_PLANE;
	localparam int WR_SPAN    = (FRAME_SIZE < 128) ? FRAME_SIZE : 128;
	localparam int OFF_W      = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
	localparam int WA_W       = (WR_SPAN > 1) ? $clog2(WR_SPAN) : 1;
	localparam int MEM_DEPTH  = 2 ** (WA_W + 1);
	localparam int PL_W       = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
	localparam int TK_W       = NUM_PLANES;
	localparam int IDX_W      = (BYTES_PER_PLANE > 1) ? $clog2(BYTES_PER_PLANE) : 1;
	localparam int CMP_W      = NUM_PLANES + 9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLEAR
	} state_t;

	state_t                state_q;
	logic [BRIGHT_W-1:0]   bright_q;
	logic                  front_q;
	logic                  swap_q;
	logic [PL_W-1:0]       plane_q;
	logic [TK_W-1:0]       ticks_q;
	logic                  show_q;
	logic                  scan_front_q;
	logic [OFF_W-1:0]      plane_base_q;
	logic [IDX_W-1:0]      idx_q;
	logic [WA_W:0]         clr_addr_q;
	logic                  clr_both_q;

	logic                  rd_s1;
	logic                  inrange_s1;
	logic                  show_s1;
	logic                  last_s1;

	logic [DATA_W-1:0]     fq_data_q [2];
	logic                  fq_last_q [2];
	logic                  fq_rp_q;
	logic                  fq_wp_q;
	logic [1:0]            fq_cnt_q;

	logic                  in_acc;
	op_t                   op;
	logic [ADDR_W-1:0]     in_addr;
	logic [DATA_W-1:0]     in_data;
	logic                  wr_en;
	logic [WA_W:0]         wr_addr;
	logic                  clr_we;
	logic                  clr_last;
	logic                  ram_we;
	logic [WA_W:0]         ram_waddr;
	logic [DATA_W-1:0]     ram_wdata;
	logic                  issue;
	logic                  pop;
	logic [2:0]            occupancy;
	logic [OFF_W-1:0]      rd_off;
	logic [WA_W:0]         rd_addr;
	logic                  rd_inrange;
	logic [DATA_W-1:0]     ram_rdata;
	logic [DATA_W-1:0]     push_data;
	logic                  idx_last;

	logic [TK_W-1:0]       weight;
	logic [TK_W-1:0]       tk_dec;
	logic [PL_W-1:0]       plane_nx;
	logic [TK_W-1:0]       ticks_nx;
	logic                  do_swap;
	logic [CMP_W-1:0]      tick_one;
	logic [CMP_W-1:0]      cmp_lhs;
	logic [CMP_W-1:0]      cmp_rhs;
	logic                  show_nx;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign op            = op_t'(s_axis_tuser);
	assign in_addr       = s_axis_tdata[ADDR_W-1:0];
	assign in_data       = s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];

	assign wr_en   = in_acc && (op == OP_WRITE) && (32'(in_addr) < FRAME_SIZE);
	assign wr_addr = {~front_q, in_addr[WA_W-1:0]};

	assign clr_we    = (state_q == ST_CLEAR);
	assign clr_last  = (&clr_addr_q[WA_W-1:0]) && (!clr_both_q || clr_addr_q[WA_W]);
	assign ram_we    = wr_en || clr_we;
	assign ram_waddr = clr_we ? clr_addr_q : wr_addr;
	assign ram_wdata = clr_we ? '0 : in_data;

	// Tick bookkeeping: weight of the current plane and the next counter values.
	always_comb begin
		weight   = TK_W'(1) << plane_q;
		tk_dec   = ticks_q - TK_W'(1);
		plane_nx = plane_q;
		ticks_nx = tk_dec;
		if (tk_dec == '0) begin
			if (32'(plane_q) == NUM_PLANES - 1) begin
				plane_nx = '0;
			end else begin
				plane_nx = plane_q + PL_W'(1);
			end
			ticks_nx = TK_W'(1) << plane_nx;
		end
		do_swap = swap_q && (plane_nx == '0) && (ticks_nx == TK_W'(1));
	end

	// The tick shows data when (index + 1) * 255 <= weight * brightness + 127.
	always_comb begin
		tick_one = CMP_W'(weight - ticks_q) + CMP_W'(1);
		cmp_lhs  = (tick_one << 8) - tick_one;
		cmp_rhs  = (CMP_W'(bright_q) << plane_q) + CMP_W'(ROUND_BIAS);
		show_nx  = (cmp_lhs <= cmp_rhs);
	end

	assign pop       = m_axis_tvalid && m_axis_tready;
	assign occupancy = 3'(fq_cnt_q) + 3'(rd_s1) - 3'(pop);
	assign issue     = (state_q == ST_SCAN) && (occupancy < 3'd2);
	assign idx_last  = (32'(idx_q) == BYTES_PER_PLANE - 1);
	assign rd_off    = plane_base_q + OFF_W'(idx_q);
	assign rd_inrange = (32'(rd_off) < WR_SPAN);
	assign rd_addr   = {scan_front_q, rd_off[WA_W-1:0]};

	blsc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MEM_DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			front_q      <= 1'b0;
			swap_q       <= 1'b0;
			plane_q      <= '0;
			ticks_q      <= TK_W'(1);
			show_q       <= 1'b0;
			scan_front_q <= 1'b0;
			plane_base_q <= '0;
			idx_q        <= '0;
			clr_addr_q   <= '0;
			clr_both_q   <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (op)
							OP_WRITE: begin
							end
							OP_SWAP: begin
								swap_q <= 1'b1;
							end
							OP_CLEAR: begin
								state_q    <= ST_CLEAR;
								clr_addr_q <= {~front_q, WA_W'(0)};
								clr_both_q <= 1'b0;
							end
							OP_TICK: begin
								state_q      <= ST_SCAN;
								show_q       <= show_nx;
								scan_front_q <= front_q;
								plane_base_q <= OFF_W'(32'(plane_q) * BYTES_PER_PLANE);
								idx_q        <= '0;
								plane_q      <= plane_nx;
								ticks_q      <= ticks_nx;
								if (do_swap) begin
									front_q <= ~front_q;
									swap_q  <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + IDX_W'(1);
						if (idx_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + (WA_W+1)'(1);
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bright_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			inrange_s1 <= rd_inrange;
			show_s1    <= show_q;
			last_s1    <= idx_last;
		end
	end

	assign push_data = (show_s1 && inrange_s1) ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fq_rp_q  <= 1'b0;
			fq_wp_q  <= 1'b0;
			fq_cnt_q <= '0;
		end else begin
			if (rd_s1) begin
				fq_wp_q <= ~fq_wp_q;
			end
			if (pop) begin
				fq_rp_q <= ~fq_rp_q;
			end
			fq_cnt_q <= fq_cnt_q + 2'(rd_s1) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			fq_data_q[fq_wp_q] <= push_data;
			fq_last_q[fq_wp_q] <= last_s1;
		end
	end

	assign m_axis_tvalid = (fq_cnt_q != '0);
	assign m_axis_tdata  = fq_data_q[fq_rp_q];
	assign m_axis_tlast  = fq_last_q[fq_rp_q];

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (fq_cnt_q != 2'd2 || pop))
		else $error("Output queue overflow.");

	a_scan_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && idx_last) |=> (state_q == ST_IDLE))
		else $error("Scan did not end after the last byte read.");

	a_swap_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(front_q) |-> ($past(swap_q) && (plane_q == '0)))
		else $error("Front frame toggled without a pending swap at plane zero.");

endmodule

// File: src/blsc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; contents are undefined after power-up.
module blsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: test/tb_top.sv
// Self-checking testbench for bitplane_led_scanner_core: a directed table, then random
// frame write / swap / scan sequences under several brightness levels, checked beat by beat.
// Depends on blsc_pkg and the scanner RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import blsc_pkg::*;

	localparam int PLANES      = 4;
	localparam int PLANE_LEN   = 32;
	localparam int FRAME_LEN   = PLANES * PLANE_LEN;
	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE      = 16;
	localparam int DRAIN       = 40;
	localparam int N_DIRECTED  = 25;
	localparam int PHASE_ITEMS = 52;

	typedef struct packed {
		logic [7:0] shift;
		logic       last;
	} pixel_beat_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] addr;
		logic [7:0] dat;
		bit         has_exp;
		logic [7:0] exp_byte;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [BRIGHT_W-1:0]    cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]        s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	bitplane_led_scanner_core #(
		.NUM_PLANES      (PLANES),
		.BYTES_PER_PLANE (PLANE_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Scanner state as the testbench sees it.
	logic [7:0]          frame_mem [0:2*FRAME_LEN-1];
	logic                front_sel = 1'b0;
	logic                swap_req = 1'b0;
	logic [1:0]          plane_now = 2'd0;
	logic [3:0]          ticks_left = 4'd1;
	logic [BRIGHT_W-1:0] bright_now = BRIGHT_RESET;

	pixel_beat_t expected_beats [$];
	int          mismatch_count = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	bit          drv_has_exp = 1'b0;
	logic [7:0]  drv_exp_byte = 8'h00;
	stim_row_t   directed_rows [0:N_DIRECTED-1];

	initial begin
		for (int i = 0; i < 2*FRAME_LEN; i++) begin
			frame_mem[i] = 8'h00;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// One accepted transaction: update the frames and counters, queue the beats a tick emits.
	task automatic scan_model_step(input op_t op, input logic [6:0] addr, input logic [7:0] dat,
		input bit has_exp, input logic [7:0] exp_byte);
		int          weight;
		int          lit_ticks;
		bit          show;
		pixel_beat_t beat;
		case (op)
			OP_WRITE: begin
				frame_mem[{~front_sel, addr}] = dat;
			end
			OP_SWAP: begin
				swap_req = 1'b1;
			end
			OP_CLEAR: begin
				for (int i = 0; i < FRAME_LEN; i++) begin
					frame_mem[{~front_sel, 7'(i)}] = 8'h00;
				end
			end
			OP_TICK: begin
				weight = 1 << plane_now;
				lit_ticks = (weight * int'(bright_now) + int'(ROUND_BIAS)) / int'(BRIGHT_RESET);
				show = (weight - int'(ticks_left)) < lit_ticks;
				for (int i = 0; i < PLANE_LEN; i++) begin
					if (has_exp) begin
						beat.shift = exp_byte;
					end else if (show) begin
						beat.shift = frame_mem[{front_sel, plane_now, 5'(i)}];
					end else begin
						beat.shift = 8'h00;
					end
					beat.last = (i == PLANE_LEN - 1);
					expected_beats.push_back(beat);
				end
				ticks_left = ticks_left - 4'd1;
				if (ticks_left == 4'd0) begin
					plane_now = plane_now + 2'd1;
					ticks_left = 4'd1 << plane_now;
				end
				if (plane_now == 2'd0 && ticks_left == 4'd1 && swap_req) begin
					front_sel = ~front_sel;
					swap_req = 1'b0;
				end
			end
		endcase
	endtask

	always @(posedge clk) begin
		pixel_beat_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				bright_now = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				scan_model_step(op_t'(s_axis_tuser), s_axis_tdata[6:0], s_axis_tdata[14:7],
					drv_has_exp, drv_exp_byte);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat", int'(m_axis_tdata), 0);
				end else begin
					want = expected_beats.pop_front();
					if (m_axis_tdata !== want.shift) begin
						report_mismatch("shift_byte", int'(m_axis_tdata), int'(want.shift));
					end
					if (m_axis_tlast !== want.last) begin
						report_mismatch("last_byte", int'(m_axis_tlast), int'(want.last));
					end
				end
			end
			if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// The receiver stalls on a rotating pattern that is redrawn at random.
	logic [15:0] stall_pattern = 16'hFFFF;
	int          stall_pos = 0;

	always @(negedge clk) begin
		if (stall_pos % 48 == 0) begin
			case ($urandom_range(0, 2))
				0: stall_pattern = 16'hFFFF;
				1: stall_pattern = 16'($urandom) | 16'h0001;
				default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
			endcase
		end
		m_axis_tready <= stall_pattern[stall_pos % 16];
		stall_pos++;
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input op_t op, input logic [6:0] addr, input logic [7:0] dat,
		input bit has_exp, input logic [7:0] exp_byte);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
			burst_left = int'($urandom_range(1, 30));
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		drv_has_exp = has_exp;
		drv_exp_byte = exp_byte;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, dat, addr};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic wait_until_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() != 0 || !s_axis_tready) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_brightness(input logic [BRIGHT_W-1:0] level);
		wait_until_idle();
		cfg_valid <= 1'b1;
		cfg_data <= level;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed frame updates: optional clear, writes, swap, then a run of ticks.
	task automatic run_random_phase(input int n_items);
		int sent;
		int k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(op_t'($urandom_range(0, 3)), 7'($urandom), 8'($urandom), 1'b0, 8'h00);
				sent++;
			end else begin
				if ($urandom_range(0, 4) == 0) begin
					send_item(OP_CLEAR, 7'($urandom), 8'($urandom), 1'b0, 8'h00);
					sent++;
				end
				k = int'($urandom_range(1, 10));
				repeat (k) begin
					send_item(OP_WRITE, 7'($urandom), 8'($urandom), 1'b0, 8'h00);
					sent++;
				end
				send_item(OP_SWAP, 7'($urandom), 8'($urandom), 1'b0, 8'h00);
				sent++;
				k = int'($urandom_range(1, 16));
				repeat (k) begin
					send_item(OP_TICK, 7'($urandom), 8'($urandom), 1'b0, 8'h00);
					sent++;
				end
			end
		end
	endtask

	initial begin
		logic [BRIGHT_W-1:0] levels [0:6];
		levels = '{8'd0, 8'd1, 8'd128, 8'd127, 8'd254, 8'd255, 8'($urandom)};
		directed_rows = '{
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_WRITE, 7'd0,   8'hFF, 1'b0, 8'h00},
			'{OP_WRITE, 7'd31,  8'h80, 1'b0, 8'h00},
			'{OP_WRITE, 7'd127, 8'hA5, 1'b0, 8'h00},
			'{OP_WRITE, 7'd64,  8'h01, 1'b0, 8'h00},
			'{OP_WRITE, 7'd1,   8'h00, 1'b0, 8'h00},
			'{OP_SWAP,  7'd0,   8'h00, 1'b0, 8'h00},
			'{OP_SWAP,  7'd127, 8'hFF, 1'b0, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b1, 8'h00},
			'{OP_TICK,  7'd0,   8'h00, 1'b0, 8'h00},
			'{OP_CLEAR, 7'd0,   8'h00, 1'b0, 8'h00},
			'{OP_TICK,  7'd127, 8'hFF, 1'b0, 8'h00}
		};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The swap requested before the plane 1 ticks lands when the scan wraps to plane 0.
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].dat,
				directed_rows[i].has_exp, directed_rows[i].exp_byte);
		end

		for (int ph = 0; ph < 7; ph++) begin
			write_brightness(levels[ph]);
			run_random_phase(PHASE_ITEMS);
		end

		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (mismatch_count == 0 && expected_beats.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
